>>> src/chs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the chained hash set.
// No dependencies; imported by every module of the block.
package chs_pkg;

    // Table geometry; the bucket count must be a power of two
    localparam int BUCKETS = 32;
    localparam int NODES   = 256;
    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int NODE_W  = $clog2(NODES);
    localparam int USED_W  = $clog2(NODES + 1);
    localparam int KEY_W   = 32;

    // Knuth multiplier: golden-ratio fraction scaled by 2^32
    localparam logic [KEY_W-1:0] HASH_MULT = 32'd2654435769;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Status codes
    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_FOUND     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic             opcode;
        logic [KEY_W-1:0] key_value;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [BKT_W-1:0] bucket_index;
    } rsp_t;

    // Chain link of one node
    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] idx;
    } link_t;

    // Write/read control toward the node store
    typedef struct packed {
        logic              key_we;
        logic [NODE_W-1:0] key_waddr;
        logic [KEY_W-1:0]  key_wdata;
        logic              link_we;
        logic [NODE_W-1:0] link_waddr;
        link_t             link_wdata;
        logic [NODE_W-1:0] raddr;
    } node_ctl_t;

endpackage

>>> src/chs_node_store.sv
`timescale 1ns / 1ps
// Node store: key memory and link memory, one shared registered read address.
// Depends on chs_pkg.
module chs_node_store
    import chs_pkg::*;
(
    input  logic             clk,
    input  node_ctl_t        ctl,
    output logic [KEY_W-1:0] rd_key,
    output link_t            rd_link
);

    logic [KEY_W-1:0] key_mem  [NODES];
    link_t            link_mem [NODES];

    // Key memory
    always_ff @(posedge clk)
    begin
        if (ctl.key_we)
        begin
            key_mem[ctl.key_waddr] <= ctl.key_wdata;
        end
        rd_key <= key_mem[ctl.raddr];
    end

    // Link memory
    always_ff @(posedge clk)
    begin
        if (ctl.link_we)
        begin
            link_mem[ctl.link_waddr] <= ctl.link_wdata;
        end
        rd_link <= link_mem[ctl.raddr];
    end

endmodule

>>> src/chained_hash_set_multiplicative.sv
`timescale 1ns / 1ps
// Chained hash set of 32-bit keys, multiplicative hash, node store of NODES entries.
// An item taken is hashed by a multiply, then dispatched on its bucket; an insert onto
// a chain also links the old tail to the new node, and a search of a used bucket walks
// the chain with one node-store read per node visited; then the result is registered.
// A new item waits until the last result is registered; a result not yet taken holds it.
// Reset (rst_n, async, low) empties all buckets and the node count; no clearing pass.
// Depends on chs_pkg and chs_node_store.
module chained_hash_set_multiplicative
    import chs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HASH = 3'd1;
    localparam logic [2:0] S_DISP = 3'd2;
    localparam logic [2:0] S_LINK = 3'd3;
    localparam logic [2:0] S_WALK = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic              op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [BKT_W-1:0]  bkt_reg;
    logic [1:0]        st_reg, st_next;
    logic [USED_W-1:0] used_reg;
    logic [BUCKETS-1:0] head_valid_reg;
    logic [NODE_W-1:0] head_reg [BUCKETS];
    logic [NODE_W-1:0] tail_reg [BUCKETS];
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;

    logic [KEY_W-1:0]  product;
    logic [NODE_W-1:0] new_node;
    logic              store_full;
    node_ctl_t         ctl;
    logic [KEY_W-1:0]  rd_key;
    link_t             rd_link;

    assign product    = key_reg * HASH_MULT;
    assign new_node   = used_reg[NODE_W-1:0];
    assign store_full = (used_reg == USED_W'(NODES));
    assign req_ready  = (state_reg == S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    chs_node_store u_store (
        .clk     (clk),
        .ctl     (ctl),
        .rd_key  (rd_key),
        .rd_link (rd_link)
    );

    // Sequencer and node-store control
    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        ctl        = '0;
        ctl.key_waddr  = new_node;
        ctl.key_wdata  = key_reg;
        ctl.link_waddr = new_node;
        ctl.raddr      = rd_link.idx;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                state_next = S_DISP;
            end
            S_DISP:
            begin
                ctl.raddr = head_reg[bkt_reg];
                if (op_reg == OP_INSERT)
                begin
                    if (store_full)
                    begin
                        st_next    = ST_FULL;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        // new node: key written, link empty
                        ctl.key_we  = 1'b1;
                        ctl.link_we = 1'b1;
                        st_next     = ST_INSERTED;
                        state_next  = head_valid_reg[bkt_reg] ? S_LINK : S_EMIT;
                    end
                end
                else if (!head_valid_reg[bkt_reg])
                begin
                    st_next    = ST_NOT_FOUND;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_LINK:
            begin
                // old tail points at the new node
                ctl.link_we         = 1'b1;
                ctl.link_waddr      = tail_reg[bkt_reg];
                ctl.link_wdata.valid = 1'b1;
                ctl.link_wdata.idx   = new_node;
                state_next          = S_EMIT;
            end
            S_WALK:
            begin
                if (rd_key == key_reg)
                begin
                    st_next    = ST_FOUND;
                    state_next = S_EMIT;
                end
                else if (!rd_link.valid)
                begin
                    st_next    = ST_NOT_FOUND;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            head_valid_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DISP && op_reg == OP_INSERT && !store_full)
            begin
                head_valid_reg[bkt_reg] <= 1'b1;
            end
            if ((state_reg == S_DISP && op_reg == OP_INSERT && !store_full
                 && !head_valid_reg[bkt_reg]) || state_reg == S_LINK)
            begin
                used_reg <= used_reg + 1'b1;
            end
            if (state_reg == S_EMIT && (!rsp_valid_reg || rsp_ready))
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers and bucket head/tail tables
    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
        if (state_reg == S_IDLE && req_valid)
        begin
            op_reg  <= req.opcode;
            key_reg <= req.key_value;
        end
        if (state_reg == S_HASH)
        begin
            bkt_reg <= product[KEY_W-1 -: BKT_W];
        end
        if (state_reg == S_DISP && op_reg == OP_INSERT && !store_full
            && !head_valid_reg[bkt_reg])
        begin
            head_reg[bkt_reg] <= new_node;
            tail_reg[bkt_reg] <= new_node;
        end
        if (state_reg == S_LINK)
        begin
            tail_reg[bkt_reg] <= new_node;
        end
        if (state_reg == S_EMIT && (!rsp_valid_reg || rsp_ready))
        begin
            rsp_reg.status       <= st_reg;
            rsp_reg.bucket_index <= bkt_reg;
        end
    end

endmodule
